### src/hsv2rgb_pkg.sv
// Shared types, field widths and constants for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam int HUE_W          = 16;
  localparam int LEVEL_W        = 13;
  localparam int FRAC_W         = 12;
  localparam int SECT_W         = 3;
  localparam int STAGES         = 6;
  localparam int FULL_SCALE_DEF = 4096;

  // 3/pi as a 0.16 fraction
  localparam logic [HUE_W-1:0]   HUE_SCALE_K  = 16'd62583;
  // one and two full turns in sector units (six sectors of 2^FRAC_W)
  localparam logic [HUE_W-1:0]   SECTOR_SPAN  = HUE_W'(6 * (1 << FRAC_W));
  localparam logic [HUE_W-1:0]   SECTOR_SPAN2 = HUE_W'(12 * (1 << FRAC_W));
  localparam logic [LEVEL_W-1:0] FRAC_ONE     = LEVEL_W'(1 << FRAC_W);

  typedef enum logic [SECT_W-1:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HUE_W-1:0]   hue_angle;
    logic [LEVEL_W-1:0] saturation;
    logic [LEVEL_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
  } rgb_t;

  // load enables of the hue stages
  typedef struct packed {
    logic mul;
    logic wrap;
  } hue_en_t;

  // load enables of the channel stages
  typedef struct packed {
    logic wgt;
    logic prod;
    logic quot;
  } lane_en_t;

endpackage

`default_nettype wire

### src/hsv2rgb_hue.sv
// Hue path: scale the angle into sector units, wrap to six sectors, split sector and fraction.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_hue (
  input  logic                               clk_i,
  input  hsv2rgb_pkg::hue_en_t               en_i,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]      hue_i,
  output hsv2rgb_pkg::sector_e               sector_o,
  output logic [hsv2rgb_pkg::FRAC_W-1:0]     frac_o
);
  import hsv2rgb_pkg::*;

  logic [2*HUE_W-1:0] prod;
  logic [HUE_W-1:0]   pos_raw_q;
  logic [HUE_W-1:0]   pos;
  sector_e            sector_q;
  logic [FRAC_W-1:0]  frac_q;

  assign prod = (2*HUE_W)'(hue_i) * (2*HUE_W)'(HUE_SCALE_K);

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      pos_raw_q <= prod[2*HUE_W-1:HUE_W];
    end
  end

  // scaled angle stays below three turns, so at most one subtract
  always_comb begin
    priority if (pos_raw_q >= SECTOR_SPAN2) begin
      pos = pos_raw_q - SECTOR_SPAN2;
    end else if (pos_raw_q >= SECTOR_SPAN) begin
      pos = pos_raw_q - SECTOR_SPAN;
    end else begin
      pos = pos_raw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.wrap) begin
      sector_q <= sector_e'(pos[FRAC_W+SECT_W-1:FRAC_W]);
      frac_q   <= pos[FRAC_W-1:0];
    end
  end

  assign sector_o = sector_q;
  assign frac_o   = frac_q;

endmodule

`default_nettype wire

### src/hsv2rgb_lane.sv
// One channel level: v * (FS*4096 - s*x) / (FS*4096), truncated and clamped to 0..FS.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_lane #(
  parameter int FULL_SCALE = hsv2rgb_pkg::FULL_SCALE_DEF
) (
  input  logic                               clk_i,
  input  hsv2rgb_pkg::lane_en_t              en_i,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0]    sat_i,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0]    weight_i,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0]    val_i,
  output logic [hsv2rgb_pkg::LEVEL_W-1:0]    level_o
);
  import hsv2rgb_pkg::*;

  localparam int FS_W    = $clog2(FULL_SCALE + 1);
  localparam int SX_W    = LEVEL_W + FRAC_W;
  localparam int ONE_W   = FS_W + FRAC_W;
  localparam int WGT_W   = ((ONE_W > SX_W) ? ONE_W : SX_W) + 1;
  localparam int NUM_W   = WGT_W + LEVEL_W + 1;
  localparam int M_W     = NUM_W - 1 - FRAC_W;
  localparam longint unsigned RECIP = (64'd1 << M_W) / FULL_SCALE;
  localparam int R_W     = $clog2(RECIP + 1);
  localparam int MR_W    = M_W + R_W;
  localparam int CLAMP_W = (FS_W > LEVEL_W + 1) ? FS_W : LEVEL_W + 1;
  localparam logic signed [WGT_W-1:0] ONE_S =
    WGT_W'(longint'(FULL_SCALE) * (longint'(1) << FRAC_W));

  logic [2*LEVEL_W-1:0]     sx_full;
  logic [SX_W-1:0]          sx_q;
  logic [LEVEL_W-1:0]       val_q;
  logic signed [WGT_W-1:0]  wgt;
  logic signed [NUM_W-1:0]  v_ext;
  logic signed [NUM_W-1:0]  w_ext;
  logic signed [NUM_W-1:0]  num_d;
  logic signed [NUM_W-1:0]  num_q;
  logic [M_W-1:0]           m_d;
  logic [MR_W-1:0]          mr;
  logic [M_W-1:0]           m_q;
  logic [LEVEL_W-1:0]       qe_q;
  logic [M_W-1:0]           qfs;
  logic [M_W-1:0]           rem;
  logic [CLAMP_W-1:0]       quo;

  assign sx_full = (2*LEVEL_W)'(sat_i) * (2*LEVEL_W)'(weight_i);

  always_ff @(posedge clk_i) begin
    if (en_i.wgt) begin
      sx_q  <= sx_full[SX_W-1:0];
      val_q <= val_i;
    end
  end

  assign wgt   = ONE_S - $signed(WGT_W'(sx_q));
  assign v_ext = NUM_W'($signed({1'b0, val_q}));
  assign w_ext = NUM_W'(wgt);
  assign num_d = v_ext * w_ext;

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      num_q <= num_d;
    end
  end

  // drop the 4096 factor by shift, zero a non-positive product,
  // then estimate the quotient by FS with a reciprocal (low by at most one)
  assign m_d = (num_q > 0) ? num_q[NUM_W-2:FRAC_W] : '0;
  assign mr  = MR_W'(m_d) * MR_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i.quot) begin
      m_q  <= m_d;
      qe_q <= mr[M_W +: LEVEL_W];
    end
  end

  assign qfs = M_W'(qe_q) * M_W'(FULL_SCALE);
  assign rem = m_q - qfs;

  always_comb begin
    quo = CLAMP_W'(qe_q);
    if (rem >= M_W'(FULL_SCALE)) begin
      quo = quo + CLAMP_W'(1);
    end
    if (quo > CLAMP_W'(FULL_SCALE)) begin
      quo = CLAMP_W'(FULL_SCALE);
    end
  end

  assign level_o = quo[LEVEL_W-1:0];

endmodule

`default_nettype wire

### src/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: handshake, stage valids, sector select.
// Usage:
//   Input channel in_valid_i / in_ready_o carries one hsv_t word (hue as a
//   Q4.12 angle in radians, saturation and brightness on the FULL_SCALE scale).
//   Output channel out_valid_o / out_ready_i carries one rgb_t word with the
//   red, green and blue levels, clamped to 0..FULL_SCALE.
//   From acceptance to out_valid_o a word passes through the hue multiply, sector
//   wrap, saturation products, brightness products, reciprocal quotient, and
//   the output register with quotient correction and sector select.
//   Throughput is one word per cycle; every stage is a register with its own
//   valid bit and a word enters each cycle while out_ready_i is high.
//   Reset clears all valid bits; the data registers are not reset.
//   When the receiver stalls, the output word holds and the words behind it
//   close up over empty stages; in_ready_o drops only once all six stages
//   hold a word.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int FULL_SCALE = hsv2rgb_pkg::FULL_SCALE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsv2rgb_pkg::hsv_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsv2rgb_pkg::rgb_t out_data_o
);
  import hsv2rgb_pkg::*;

  localparam int NUM_LANES = 4;
  localparam int LANE_V    = 0;
  localparam int LANE_P    = 1;
  localparam int LANE_Q    = 2;
  localparam int LANE_T    = 3;

  logic [STAGES-1:0]  vld_q;
  logic [STAGES-1:0]  vld_d;
  logic [STAGES-1:0]  en;

  logic [LEVEL_W-1:0] sat1_q, val1_q, sat2_q, val2_q;
  sector_e            sect2;
  logic [FRAC_W-1:0]  frac2;
  sector_e            sect3_q, sect4_q, sect5_q;
  hue_en_t            hue_en;
  lane_en_t           lane_en;
  logic [LEVEL_W-1:0] lane_x   [NUM_LANES];
  logic [LEVEL_W-1:0] lane_lvl [NUM_LANES];
  rgb_t               out_d, out_q;

  // a stage loads when empty or when the stage after it moves on
  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || out_ready_i;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    for (int i = 0; i < STAGES; i++) begin
      if (en[i]) begin
        vld_d[i] = (i == 0) ? in_valid_i : vld_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign hue_en  = '{mul: en[0], wrap: en[1]};
  assign lane_en = '{wgt: en[2], prod: en[3], quot: en[4]};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sat1_q <= in_data_i.saturation;
      val1_q <= in_data_i.brightness;
    end
    if (en[1]) begin
      sat2_q <= sat1_q;
      val2_q <= val1_q;
    end
    if (en[2]) begin
      sect3_q <= sect2;
    end
    if (en[3]) begin
      sect4_q <= sect3_q;
    end
    if (en[4]) begin
      sect5_q <= sect4_q;
    end
  end

  hsv2rgb_hue u_hue (
    .clk_i    (clk_i),
    .en_i     (hue_en),
    .hue_i    (in_data_i.hue_angle),
    .sector_o (sect2),
    .frac_o   (frac2)
  );

  // saturation weight of each candidate: v none, p full, q f, t 1-f
  assign lane_x[LANE_V] = '0;
  assign lane_x[LANE_P] = FRAC_ONE;
  assign lane_x[LANE_Q] = LEVEL_W'(frac2);
  assign lane_x[LANE_T] = FRAC_ONE - LEVEL_W'(frac2);

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    hsv2rgb_lane #(
      .FULL_SCALE (FULL_SCALE)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (lane_en),
      .sat_i    (sat2_q),
      .weight_i (lane_x[g]),
      .val_i    (val2_q),
      .level_o  (lane_lvl[g])
    );
  end

  always_comb begin
    unique case (sect5_q)
      SECT_RED: begin
        out_d = '{lane_lvl[LANE_V], lane_lvl[LANE_T], lane_lvl[LANE_P]};
      end
      SECT_YELLOW: begin
        out_d = '{lane_lvl[LANE_Q], lane_lvl[LANE_V], lane_lvl[LANE_P]};
      end
      SECT_GREEN: begin
        out_d = '{lane_lvl[LANE_P], lane_lvl[LANE_V], lane_lvl[LANE_T]};
      end
      SECT_CYAN: begin
        out_d = '{lane_lvl[LANE_P], lane_lvl[LANE_Q], lane_lvl[LANE_V]};
      end
      SECT_BLUE: begin
        out_d = '{lane_lvl[LANE_T], lane_lvl[LANE_P], lane_lvl[LANE_V]};
      end
      default: begin
        out_d = '{lane_lvl[LANE_V], lane_lvl[LANE_P], lane_lvl[LANE_Q]};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[STAGES-1]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[STAGES-1];
  assign out_data_o  = out_q;

  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is being taken");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted into a full stalled pipeline");

  a_accept_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted word missing from first stage");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((FULL_SCALE > 8191) ||
                     ((out_data_o.red_level <= FULL_SCALE) &&
                      (out_data_o.green_level <= FULL_SCALE) &&
                      (out_data_o.blue_level <= FULL_SCALE))))
    else $error("output level above full scale");

endmodule

`default_nettype wire
